>>> hdl/ipsd_pkg.sv
// Shared types, field widths, register codes and defaults of the stride prefetcher.
`default_nettype none

package ipsd_pkg;

  // Fixed field widths.
  localparam int unsigned IP_W      = 48;
  localparam int unsigned LINE_W    = 42;
  localparam int unsigned CYCLE_W   = 48;
  localparam int unsigned STRIDE_W  = 43;
  localparam int unsigned CONF_W    = 2;
  localparam int unsigned PF_ADDR_W = 48;
  localparam int unsigned DELAY_W   = 8;
  localparam int unsigned DEGREE_W  = 4;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_ISSUE_DELAY      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOKAHEAD_DEGREE = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIDENCE_LIMIT = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VIRTUAL_MODE     = 8'd3;

  localparam logic [DELAY_W-1:0]  ISSUE_DELAY_RST  = 8'd30;
  localparam logic [DEGREE_W-1:0] DEGREE_RST       = 4'd3;
  localparam logic [CONF_W-1:0]   CONF_LIMIT_RST   = 2'd2;
  localparam logic                VIRTUAL_MODE_RST = 1'b0;

  // Request kinds.
  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Default geometry.
  localparam int unsigned DEF_TRACK_SETS = 256;
  localparam int unsigned DEF_TRACK_WAYS = 4;
  localparam int unsigned DEF_BLOCK_BITS = 6;
  localparam int unsigned DEF_PAGE_BITS  = 12;
  localparam int unsigned DEF_ADDR_BITS  = 48;

  // Set index reduction: bits of the ip consumed per cycle, and the number of cycles.
  localparam int unsigned MOD_DIGIT_BITS = 4;
  localparam int unsigned MOD_STEPS      = IP_W / MOD_DIGIT_BITS;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [DELAY_W-1:0]  issue_delay;
    logic [DEGREE_W-1:0] degree;
    logic [CONF_W-1:0]   conf_limit;
    logic                virtual_mode;
  } cfg_t;

  typedef struct packed {
    logic               is_tick;
    logic [IP_W-1:0]    ip;
    logic [LINE_W-1:0]  line;
    logic [CYCLE_W-1:0] cycle_now;
    logic               below_half;
    logic               accepted;
  } item_t;

  typedef struct packed {
    logic                valid;
    logic [IP_W-1:0]     tag;
    logic [LINE_W-1:0]   last_line;
    logic [STRIDE_W-1:0] stride;
    logic [CONF_W-1:0]   conf;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

>>> hdl/ip_stride_prefetcher_delayed_core.sv
// Top level of the instruction-pointer stride prefetcher with delayed lookahead issue.
//
// Requests enter on the in_valid/in_ready channel: req_type selects a cache access, which
// trains the tracker, or a cycle tick, which may issue the next prefetch of the lookahead.
// Every request yields exactly one result on out_valid/out_ready; pf_valid marks results
// that carry a prefetch. Configuration registers are written on cfg_valid/cfg_ready, which
// is always ready; writes are expected only while no request is in flight.
// A tick is answered from the lookahead; an access passes through the read, select and
// write of the tracker RAM for its set. When the set count is not a power of two, the
// front end first reduces the ip of an access to its set index. The front end takes one
// request a cycle into its hold stage and a two-entry queue while the queue has room and
// no reduction is pending; the back end retires one tick per cycle while results are
// taken, and one access at a time. A stalled result register holds its request while
// the front keeps accepting until the queue is full, then in_ready drops.
// Reset returns the registers to their defaults, clears the lookahead and marks every
// tracker set as never written with flip-flops, so no clearing pass runs and the block
// takes requests from the first cycle after reset.
`default_nettype none

module ip_stride_prefetcher_delayed_core #(
  parameter int unsigned TRACK_SETS = ipsd_pkg::DEF_TRACK_SETS,
  parameter int unsigned TRACK_WAYS = ipsd_pkg::DEF_TRACK_WAYS,
  parameter int unsigned BLOCK_BITS = ipsd_pkg::DEF_BLOCK_BITS,
  parameter int unsigned PAGE_BITS  = ipsd_pkg::DEF_PAGE_BITS,
  parameter int unsigned ADDR_BITS  = ipsd_pkg::DEF_ADDR_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Request channel.
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               req_type,
  input  wire logic [ipsd_pkg::IP_W-1:0]          ip,
  input  wire logic [ipsd_pkg::LINE_W-1:0]        line_address,
  input  wire logic [ipsd_pkg::CYCLE_W-1:0]       cycle_now,
  input  wire logic                               mshr_below_half,
  input  wire logic                               prefetch_accepted,
  // Result channel.
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    pf_valid,
  output logic      [ipsd_pkg::PF_ADDR_W-1:0]     pf_address,
  output logic                                    fill_this_level,
  // Configuration write channel.
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ipsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ipsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned SET_BITS = (TRACK_SETS > 1) ? $clog2(TRACK_SETS) : 1;

  ipsd_pkg::cfg_t      cfg;
  logic                q_valid;
  logic                q_pop;
  ipsd_pkg::item_t     q_item;
  logic [SET_BITS-1:0] q_set;

  // Registers are taken at any time; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.issue_delay  <= ipsd_pkg::ISSUE_DELAY_RST;
      cfg.degree       <= ipsd_pkg::DEGREE_RST;
      cfg.conf_limit   <= ipsd_pkg::CONF_LIMIT_RST;
      cfg.virtual_mode <= ipsd_pkg::VIRTUAL_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ipsd_pkg::REG_ISSUE_DELAY:
          cfg.issue_delay <= cfg_data[ipsd_pkg::DELAY_W-1:0];
        ipsd_pkg::REG_LOOKAHEAD_DEGREE:
          cfg.degree <= cfg_data[ipsd_pkg::DEGREE_W-1:0];
        ipsd_pkg::REG_CONFIDENCE_LIMIT:
          cfg.conf_limit <= cfg_data[ipsd_pkg::CONF_W-1:0];
        ipsd_pkg::REG_VIRTUAL_MODE:
          cfg.virtual_mode <= cfg_data[0];
        default: cfg <= cfg;
      endcase
    end
  end

  // Front end: accepts and classifies requests, works out the set index, and queues them.
  ipsd_front #(
    .TRACK_SETS (TRACK_SETS),
    .SET_BITS   (SET_BITS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .req_type          (req_type),
    .ip                (ip),
    .line_address      (line_address),
    .cycle_now         (cycle_now),
    .mshr_below_half   (mshr_below_half),
    .prefetch_accepted (prefetch_accepted),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_item            (q_item),
    .q_set             (q_set)
  );

  // Back end: trains the tracker, runs the lookahead and holds the result register.
  ipsd_back #(
    .TRACK_SETS (TRACK_SETS),
    .TRACK_WAYS (TRACK_WAYS),
    .BLOCK_BITS (BLOCK_BITS),
    .PAGE_BITS  (PAGE_BITS),
    .ADDR_BITS  (ADDR_BITS),
    .SET_BITS   (SET_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_item          (q_item),
    .q_set           (q_set),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pf_valid        (pf_valid),
    .pf_address      (pf_address),
    .fill_this_level (fill_this_level)
  );

endmodule

`default_nettype wire

>>> hdl/ipsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ipsd_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/ipsd_front.sv
// Front end: accepts requests, classifies them and computes the tracker set index.
`default_nettype none

module ipsd_front #(
  parameter int unsigned TRACK_SETS = ipsd_pkg::DEF_TRACK_SETS,
  parameter int unsigned SET_BITS   = (TRACK_SETS > 1) ? $clog2(TRACK_SETS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic [ipsd_pkg::IP_W-1:0]     ip,
  input  wire logic [ipsd_pkg::LINE_W-1:0]   line_address,
  input  wire logic [ipsd_pkg::CYCLE_W-1:0]  cycle_now,
  input  wire logic                          mshr_below_half,
  input  wire logic                          prefetch_accepted,
  output logic                               q_valid,
  input  wire logic                          q_pop,
  output ipsd_pkg::item_t                    q_item,
  output logic      [SET_BITS-1:0]           q_set
);

  localparam bit          SETS_POW2 = (TRACK_SETS & (TRACK_SETS - 1)) == 0;
  localparam int unsigned STEP_W    = $clog2(ipsd_pkg::MOD_STEPS + 1);
  localparam int unsigned PTR_W     = $clog2(ipsd_pkg::QUEUE_DEPTH);
  localparam int unsigned COUNT_W   = $clog2(ipsd_pkg::QUEUE_DEPTH + 1);
  localparam logic [SET_BITS:0] SET_LIMIT = (SET_BITS + 1)'(TRACK_SETS);

  logic                          hold_valid;
  ipsd_pkg::item_t               hold;
  logic [SET_BITS-1:0]           residue;
  logic [SET_BITS-1:0]           residue_next;
  logic [ipsd_pkg::IP_W-1:0]     digits;
  logic [ipsd_pkg::IP_W-1:0]     digits_next;
  logic [STEP_W-1:0]             step;
  logic                          idx_done;
  logic                          push;
  logic                          accept;
  logic [SET_BITS-1:0]           hold_set;

  ipsd_pkg::item_t               slot     [ipsd_pkg::QUEUE_DEPTH];
  logic [SET_BITS-1:0]           slot_set [ipsd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]              rd_ptr;
  logic [PTR_W-1:0]              wr_ptr;
  logic [COUNT_W-1:0]            count;

  // Remainder of ip by the set count, most significant bits first, MOD_DIGIT_BITS bits a cycle.
  always_comb begin
    logic [SET_BITS:0] t;
    residue_next = residue;
    digits_next  = digits;
    for (int k = 0; k < ipsd_pkg::MOD_DIGIT_BITS; k++) begin
      t           = {residue_next, digits_next[ipsd_pkg::IP_W-1]};
      digits_next = {digits_next[ipsd_pkg::IP_W-2:0], 1'b0};
      if (t >= SET_LIMIT) begin
        t = t - SET_LIMIT;
      end
      residue_next = t[SET_BITS-1:0];
    end
  end

  assign idx_done = hold.is_tick || SETS_POW2 || (step == STEP_W'(ipsd_pkg::MOD_STEPS));
  assign hold_set = SETS_POW2 ?
                    SET_BITS'(hold.ip & ipsd_pkg::IP_W'(TRACK_SETS - 1)) : residue;
  assign push     = hold_valid && idx_done && (count != COUNT_W'(ipsd_pkg::QUEUE_DEPTH));
  assign in_ready = !hold_valid || push;
  assign accept   = in_valid && in_ready;

  assign q_valid  = count != '0;
  assign q_item   = slot[rd_ptr];
  assign q_set    = slot_set[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      step       <= '0;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      count      <= '0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (push) begin
        hold_valid <= 1'b0;
      end
      if (accept) begin
        step <= '0;
      end else if (hold_valid && !idx_done) begin
        step <= step + STEP_W'(1);
      end
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + COUNT_W'(1);
        2'b01:   count <= count - COUNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.is_tick    <= (req_type == ipsd_pkg::REQ_TICK);
      hold.ip         <= ip;
      hold.line       <= line_address;
      hold.cycle_now  <= cycle_now;
      hold.below_half <= mshr_below_half;
      hold.accepted   <= prefetch_accepted;
      residue         <= '0;
      digits          <= ip;
    end else if (hold_valid && !idx_done) begin
      residue <= residue_next;
      digits  <= digits_next;
    end
    if (push) begin
      slot[wr_ptr]     <= hold;
      slot_set[wr_ptr] <= hold_set;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ipsd_back.sv
// Back end: tracker read-modify-write, lookahead state and the result register.
`default_nettype none

module ipsd_back #(
  parameter int unsigned TRACK_SETS = ipsd_pkg::DEF_TRACK_SETS,
  parameter int unsigned TRACK_WAYS = ipsd_pkg::DEF_TRACK_WAYS,
  parameter int unsigned BLOCK_BITS = ipsd_pkg::DEF_BLOCK_BITS,
  parameter int unsigned PAGE_BITS  = ipsd_pkg::DEF_PAGE_BITS,
  parameter int unsigned ADDR_BITS  = ipsd_pkg::DEF_ADDR_BITS,
  parameter int unsigned SET_BITS   = (TRACK_SETS > 1) ? $clog2(TRACK_SETS) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  ipsd_pkg::cfg_t                        cfg,
  input  wire logic                             q_valid,
  output logic                                  q_pop,
  input  ipsd_pkg::item_t                       q_item,
  input  wire logic [SET_BITS-1:0]              q_set,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  pf_valid,
  output logic      [ipsd_pkg::PF_ADDR_W-1:0]   pf_address,
  output logic                                  fill_this_level
);

  localparam int unsigned WAY_BITS = (TRACK_WAYS > 1) ? $clog2(TRACK_WAYS) : 1;
  localparam int unsigned ENTRY_W  = ipsd_pkg::ENTRY_W;
  localparam int unsigned LRU_BASE = TRACK_WAYS * ENTRY_W;
  localparam int unsigned ROW_W    = LRU_BASE + TRACK_WAYS * WAY_BITS;
  localparam int unsigned STRIDE_W = ipsd_pkg::STRIDE_W;
  localparam int unsigned LINE_W   = ipsd_pkg::LINE_W;

  typedef enum logic [1:0] {S_IDLE, S_SELECT, S_WRITE} state_t;

  state_t                             state;
  ipsd_pkg::item_t                    cur;
  logic [SET_BITS-1:0]                cur_set;
  logic [TRACK_SETS-1:0]              row_seen;
  logic [WAY_BITS-1:0]                sel_way;
  logic                               sel_hit;
  logic [WAY_BITS-1:0]                sel_lru [TRACK_WAYS];

  logic                               look_valid;
  logic [ADDR_BITS-1:0]               look_address;
  logic [STRIDE_W-1:0]                look_stride;
  logic [ipsd_pkg::DEGREE_W-1:0]      look_remaining;
  logic [ipsd_pkg::CYCLE_W-1:0]       look_issue_time;

  logic                               out_free;
  logic                               rd_en;
  logic                               wr_en;
  logic [ROW_W-1:0]                   rd_data;
  logic [ROW_W-1:0]                   wr_data;

  ipsd_pkg::entry_t                   eff_entry [TRACK_WAYS];
  logic [WAY_BITS-1:0]                eff_lru   [TRACK_WAYS];

  logic                               hit_found;
  logic [WAY_BITS-1:0]                victim;
  logic [WAY_BITS-1:0]                lru_new   [TRACK_WAYS];

  ipsd_pkg::entry_t                   hit_e;
  ipsd_pkg::entry_t                   new_entry;
  logic [STRIDE_W-1:0]                stride_new;
  logic [ipsd_pkg::CONF_W-1:0]        conf_hit;
  logic                               arm;
  logic [ADDR_BITS-1:0]               arm_address;
  logic [ADDR_BITS+LINE_W+BLOCK_BITS-1:0] arm_wide;

  logic [ADDR_BITS+STRIDE_W+BLOCK_BITS-1:0] step_wide;
  logic [ADDR_BITS-1:0]               next_address;
  logic [ADDR_BITS+ipsd_pkg::PF_ADDR_W-1:0] pf_wide;
  logic                               due;
  logic                               page_ok;
  logic                               issue;
  logic [ipsd_pkg::DEGREE_W-1:0]      rem_after;
  logic [ipsd_pkg::CYCLE_W-1:0]       tick_issue_time;
  logic [ipsd_pkg::CYCLE_W-1:0]       arm_issue_time;

  ipsd_ram #(
    .WIDTH  (ROW_W),
    .DEPTH  (TRACK_SETS),
    .ADDR_W (SET_BITS)
  ) u_track_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_set),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (q_set),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && q_valid && out_free;
  assign rd_en    = q_pop && !q_item.is_tick;
  assign wr_en    = state == S_WRITE;

  // A set never written since reset reads as all ways invalid, LRU in way order.
  always_comb begin
    for (int w = 0; w < TRACK_WAYS; w++) begin
      eff_entry[w] = rd_data[w*ENTRY_W +: ENTRY_W];
      eff_lru[w]   = rd_data[LRU_BASE + w*WAY_BITS +: WAY_BITS];
      if (!row_seen[cur_set]) begin
        eff_entry[w].valid = 1'b0;
        eff_lru[w]         = WAY_BITS'(w);
      end
    end
  end

  // Way selection: first hit, else first invalid way, else least recently used.
  always_comb begin
    logic                inv_found;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] inv_way;
    logic                pos_found;
    logic [WAY_BITS-1:0] pos;
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = 0; w < TRACK_WAYS; w++) begin
      if (!hit_found && eff_entry[w].valid && (eff_entry[w].tag == cur.ip)) begin
        hit_found = 1'b1;
        hit_way   = WAY_BITS'(w);
      end
      if (!inv_found && !eff_entry[w].valid) begin
        inv_found = 1'b1;
        inv_way   = WAY_BITS'(w);
      end
    end
    priority if (hit_found) begin
      victim = hit_way;
    end else if (inv_found) begin
      victim = inv_way;
    end else begin
      victim = eff_lru[0];
    end
    pos_found = 1'b0;
    pos       = '0;
    for (int p = 0; p < TRACK_WAYS; p++) begin
      if (!pos_found && (eff_lru[p] == victim)) begin
        pos_found = 1'b1;
        pos       = WAY_BITS'(p);
      end
    end
    for (int q = 0; q < TRACK_WAYS; q++) begin
      lru_new[q] = eff_lru[q];
    end
    if (pos_found) begin
      for (int q = 0; q + 1 < TRACK_WAYS; q++) begin
        lru_new[q] = (WAY_BITS'(q) < pos) ? eff_lru[q] : eff_lru[q+1];
      end
      lru_new[TRACK_WAYS-1] = victim;
    end
  end

  // Stride and confidence update of the selected way.
  always_comb begin
    logic [ipsd_pkg::CONF_W:0]   conf_up;
    logic [ipsd_pkg::CONF_W-1:0] conf_inc;
    logic [ipsd_pkg::CONF_W-1:0] conf_dec;
    logic                        arm_conf;
    hit_e      = eff_entry[sel_way];
    stride_new = {1'b0, cur.line} - {1'b0, hit_e.last_line};
    conf_up    = {1'b0, hit_e.conf} + 3'd1;
    conf_inc   = (conf_up < {1'b0, cfg.conf_limit}) ? conf_up[ipsd_pkg::CONF_W-1:0]
                                                    : cfg.conf_limit;
    conf_dec   = (hit_e.conf > 2'd1) ? hit_e.conf - 2'd1 : 2'd0;
    conf_hit   = (stride_new == hit_e.stride) ? conf_inc : conf_dec;
    arm_conf   = (cfg.conf_limit == 2'd0) || (conf_hit >= cfg.conf_limit - 2'd1);
    arm        = sel_hit && (stride_new != '0) && arm_conf;

    new_entry.valid     = 1'b1;
    new_entry.tag       = cur.ip;
    new_entry.last_line = cur.line;
    new_entry.stride    = sel_hit ? stride_new : '0;
    new_entry.conf      = sel_hit ? conf_hit : '0;

    for (int w = 0; w < TRACK_WAYS; w++) begin
      wr_data[w*ENTRY_W +: ENTRY_W] = (WAY_BITS'(w) == sel_way) ? new_entry : eff_entry[w];
      wr_data[LRU_BASE + w*WAY_BITS +: WAY_BITS] = sel_lru[w];
    end
  end

  assign arm_wide       = {{ADDR_BITS{1'b0}}, cur.line, {BLOCK_BITS{1'b0}}};
  assign arm_address    = arm_wide[ADDR_BITS-1:0];
  assign arm_issue_time = cur.cycle_now + ipsd_pkg::CYCLE_W'(cfg.issue_delay);

  // Lookahead step: sign-extended stride in lines, scaled to bytes.
  assign step_wide       = {{ADDR_BITS{look_stride[STRIDE_W-1]}}, look_stride,
                            {BLOCK_BITS{1'b0}}};
  assign next_address    = look_address + step_wide[ADDR_BITS-1:0];
  assign pf_wide         = {{ipsd_pkg::PF_ADDR_W{1'b0}}, next_address};
  assign due             = look_valid && (look_issue_time <= q_item.cycle_now);
  assign page_ok         = cfg.virtual_mode ||
                           (next_address[ADDR_BITS-1:PAGE_BITS] ==
                            look_address[ADDR_BITS-1:PAGE_BITS]);
  assign issue           = due && page_ok;
  assign rem_after       = q_item.accepted ? look_remaining - 4'd1 : look_remaining;
  assign tick_issue_time = q_item.cycle_now + ipsd_pkg::CYCLE_W'(cfg.issue_delay);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      row_seen        <= '0;
      look_valid      <= 1'b0;
      look_address    <= '0;
      look_stride     <= '0;
      look_remaining  <= '0;
      look_issue_time <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_item.is_tick) begin
              out_valid       <= 1'b1;
              pf_valid        <= issue;
              pf_address      <= issue ? pf_wide[ipsd_pkg::PF_ADDR_W-1:0] : '0;
              fill_this_level <= issue && q_item.below_half;
              if (due) begin
                if (page_ok) begin
                  if (q_item.accepted) begin
                    look_address    <= next_address;
                    look_remaining  <= rem_after;
                    look_issue_time <= tick_issue_time;
                  end
                  look_valid <= rem_after != '0;
                end else begin
                  look_valid <= 1'b0;
                end
              end
            end else begin
              cur     <= q_item;
              cur_set <= q_set;
              state   <= S_SELECT;
            end
          end
        end
        S_SELECT: begin
          sel_way <= victim;
          sel_hit <= hit_found;
          for (int w = 0; w < TRACK_WAYS; w++) begin
            sel_lru[w] <= lru_new[w];
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          out_valid         <= 1'b1;
          pf_valid          <= 1'b0;
          pf_address        <= '0;
          fill_this_level   <= 1'b0;
          row_seen[cur_set] <= 1'b1;
          if (arm) begin
            look_valid      <= cfg.degree != '0;
            look_address    <= arm_address;
            look_stride     <= stride_new;
            look_remaining  <= cfg.degree;
            look_issue_time <= arm_issue_time;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_look_has_work: assert property (@(posedge clk) disable iff (rst)
    look_valid |-> (look_remaining != '0))
    else $error("armed lookahead with no prefetches left");

  a_idle_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pf_valid) |-> ((pf_address == '0) && !fill_this_level))
    else $error("result without prefetch carries address or fill");

  a_write_marks_set: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> row_seen[$past(cur_set)])
    else $error("tracker set written but not marked");

  a_write_after_select: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> $past(state == S_SELECT))
    else $error("tracker write without a selection cycle");

endmodule

`default_nettype wire

>>> tb/ip_stride_prefetcher_delayed_core_tb.sv
// Self-checking testbench for the instruction-pointer stride prefetcher core.
`timescale 1ns / 100ps

module ip_stride_prefetcher_delayed_core_tb;
  import ipsd_pkg::*;

  // Geometry of the block as instantiated. The predictor below uses the same values.
  localparam int unsigned SETS = DEF_TRACK_SETS;
  localparam int unsigned WAYS = DEF_TRACK_WAYS;
  localparam int unsigned BLK  = DEF_BLOCK_BITS;
  localparam int unsigned PAGE = DEF_PAGE_BITS;

  // The slowest correct run has about 820 requests, each at worst with a full sender gap,
  // a full result stall and the access latency, plus one long stall. The limit leaves
  // several times the length of that run as margin.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Every request returns exactly one result, so once nothing is pending the block only
  // needs its pipeline depth to go quiet.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned STREAMS       = 6;

  localparam logic [IP_W-1:0]    IP_TOP    = '1;
  localparam logic [LINE_W-1:0]  LINE_TOP  = '1;
  localparam logic [CYCLE_W-1:0] CYCLE_TOP = '1;

  typedef struct packed {
    logic                 pf_valid;
    logic [PF_ADDR_W-1:0] pf_address;
    logic                 fill_this_level;
  } prefetch_result_t;

  // Clock, reset and block ports. Every input holds a known value from time zero.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   req_type = REQ_ACCESS;
  logic [IP_W-1:0]        ip = '0;
  logic [LINE_W-1:0]      line_address = '0;
  logic [CYCLE_W-1:0]     cycle_now = '0;
  logic                   mshr_below_half = 1'b0;
  logic                   prefetch_accepted = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   pf_valid;
  logic [PF_ADDR_W-1:0]   pf_address;
  logic                   fill_this_level;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  ip_stride_prefetcher_delayed_core DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .req_type          (req_type),
    .ip                (ip),
    .line_address      (line_address),
    .cycle_now         (cycle_now),
    .mshr_below_half   (mshr_below_half),
    .prefetch_accepted (prefetch_accepted),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .pf_valid          (pf_valid),
    .pf_address        (pf_address),
    .fill_this_level   (fill_this_level),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------------------
  // Prefetch predictor. It keeps its own copy of the registers, the tracker and the
  // single lookahead, and is advanced once for every request the block accepts.
  // ------------------------------------------------------------------------------------
  logic [DELAY_W-1:0]  cfg_delay;
  logic [DEGREE_W-1:0] cfg_degree;
  logic [CONF_W-1:0]   cfg_conf_limit;
  logic                cfg_virtual;

  logic                trk_valid  [SETS][WAYS];
  logic [IP_W-1:0]     trk_tag    [SETS][WAYS];
  logic [LINE_W-1:0]   trk_last   [SETS][WAYS];
  logic [STRIDE_W-1:0] trk_stride [SETS][WAYS];
  logic [CONF_W-1:0]   trk_conf   [SETS][WAYS];
  // Replacement order per set: position 0 holds the least recently used way.
  int unsigned         trk_lru    [SETS][WAYS];

  logic                 la_valid;
  logic [PF_ADDR_W-1:0] la_addr;
  logic [STRIDE_W-1:0]  la_stride;
  logic [DEGREE_W-1:0]  la_left;
  logic [CYCLE_W-1:0]   la_due;

  // Results the block still owes, oldest first.
  prefetch_result_t pending_results[$];

  int unsigned mismatch_count;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned prefetch_results;
  int unsigned register_writes;
  int unsigned cycle_count;

  // Idle shaping shared by the sender, the result sink and the back-pressure test.
  int unsigned send_gap_max;
  int unsigned sink_gap_max;
  int unsigned hold_request;

  // Random traffic streams: each stream is one instruction with its own stride.
  logic [IP_W-1:0]   stream_ip   [STREAMS];
  logic [LINE_W-1:0] stream_line [STREAMS];
  logic [LINE_W-1:0] stream_step [STREAMS];
  logic [CYCLE_W-1:0] cache_now;

  task automatic reset_predictor();
    cfg_delay      = ISSUE_DELAY_RST;
    cfg_degree     = DEGREE_RST;
    cfg_conf_limit = CONF_LIMIT_RST;
    cfg_virtual    = VIRTUAL_MODE_RST;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        trk_valid[s][w] = 1'b0;
        trk_lru[s][w]   = w;
      end
    end
    la_valid  = 1'b0;
    la_addr   = '0;
    la_stride = '0;
    la_left   = '0;
    la_due    = '0;
  endtask

  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] index,
                                         input logic [CFG_DATA_W-1:0] data);
    // Indexes outside the register map are dropped without effect.
    case (index)
      REG_ISSUE_DELAY:      cfg_delay      = data[DELAY_W-1:0];
      REG_LOOKAHEAD_DEGREE: cfg_degree     = data[DEGREE_W-1:0];
      REG_CONFIDENCE_LIMIT: cfg_conf_limit = data[CONF_W-1:0];
      REG_VIRTUAL_MODE:     cfg_virtual    = data[0];
      default: ;
    endcase
  endfunction

  // An access trains the tracker entry of its ip and may re-arm the lookahead.
  function automatic void train_tracker(input item_t it);
    int unsigned         set_idx;
    int unsigned         way;
    int unsigned         pos;
    int                  w;
    int                  conf;
    int                  limit;
    logic [STRIDE_W-1:0] delta;
    set_idx = it.ip % SETS;
    way = WAYS;
    for (w = WAYS - 1; w >= 0; w--)
      if (trk_valid[set_idx][w] && trk_tag[set_idx][w] == it.ip) way = w;
    if (way < WAYS) begin
      // The line stride is exact in 43-bit two's complement.
      limit = cfg_conf_limit;
      delta = {1'b0, it.line} - {1'b0, trk_last[set_idx][way]};
      conf  = trk_conf[set_idx][way];
      if (delta == trk_stride[set_idx][way]) conf = (conf + 1 < limit) ? conf + 1 : limit;
      else conf = (conf - 1 > 0) ? conf - 1 : 0;
      // With a confidence limit of zero the threshold is negative, so any nonzero
      // stride arms. A degree of zero arms nothing but still overwrites the lookahead.
      if (delta != '0 && conf >= limit - 1) begin
        la_valid  = (cfg_degree != '0);
        la_addr   = PF_ADDR_W'(it.line) << BLK;
        la_stride = delta;
        la_left   = cfg_degree;
        la_due    = it.cycle_now + CYCLE_W'(cfg_delay);
      end
    end else begin
      // Miss: lowest invalid way first, otherwise the least recently used one.
      for (w = WAYS - 1; w >= 0; w--)
        if (!trk_valid[set_idx][w]) way = w;
      if (way == WAYS) way = trk_lru[set_idx][0];
      delta = '0;
      conf  = 0;
    end
    trk_valid[set_idx][way]  = 1'b1;
    trk_tag[set_idx][way]    = it.ip;
    trk_last[set_idx][way]   = it.line;
    trk_stride[set_idx][way] = delta;
    trk_conf[set_idx][way]   = conf[CONF_W-1:0];
    pos = 0;
    while (trk_lru[set_idx][pos] != way) pos++;
    for (int p = pos; p + 1 < WAYS; p++) trk_lru[set_idx][p] = trk_lru[set_idx][p + 1];
    trk_lru[set_idx][WAYS-1] = way;
  endfunction

  // A tick may issue the next line of the lookahead once its issue time has come.
  function automatic prefetch_result_t advance_lookahead(input item_t it);
    prefetch_result_t     res;
    logic [PF_ADDR_W-1:0] next_addr;
    res = '0;
    if (la_valid && la_due <= it.cycle_now) begin
      next_addr = la_addr + ({{(PF_ADDR_W - STRIDE_W){la_stride[STRIDE_W-1]}}, la_stride}
                             << BLK);
      if (cfg_virtual || (next_addr >> PAGE) == (la_addr >> PAGE)) begin
        res.pf_valid        = 1'b1;
        res.pf_address      = next_addr;
        res.fill_this_level = it.below_half;
        // A refused prefetch leaves the lookahead as it is, to be retried.
        if (it.accepted) begin
          la_addr = next_addr;
          la_left = la_left - 1'b1;
          la_due  = it.cycle_now + CYCLE_W'(cfg_delay);
        end
        if (la_left == '0) la_valid = 1'b0;
      end else begin
        // Crossing into another page ends the lookahead quietly.
        la_valid = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic prefetch_result_t predict_request(input item_t it);
    if (it.is_tick == REQ_TICK) return advance_lookahead(it);
    train_tracker(it);
    return '0;
  endfunction

  // ------------------------------------------------------------------------------------
  // Driving. Inputs change on the falling edge; handshakes are sampled on the rising edge.
  // ------------------------------------------------------------------------------------
  function automatic item_t make_item(input logic kind, input logic [IP_W-1:0] ip_v,
                                      input logic [LINE_W-1:0] line_v,
                                      input logic [CYCLE_W-1:0] now_v,
                                      input logic below, input logic acc);
    item_t it;
    it.is_tick    = kind;
    it.ip         = ip_v;
    it.line       = line_v;
    it.cycle_now  = now_v;
    it.below_half = below;
    it.accepted   = acc;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offers one request and records what it should produce once it is taken. A valid
  // that stays up for the next request is never dropped in between.
  task automatic send_request(input item_t it);
    int unsigned gap;
    gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    req_type          <= it.is_tick;
    ip                <= it.ip;
    line_address      <= it.line;
    cycle_now         <= it.cycle_now;
    mshr_below_half   <= it.below_half;
    prefetch_accepted <= it.accepted;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_request(it));
    requests_sent++;
  endtask

  // Drops the request valid and waits until every owed result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes are only issued while the block holds no request.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(index, data);
    register_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_registers(input logic [7:0] delay, input logic [7:0] degree,
                                     input logic [7:0] limit, input logic [7:0] virt);
    write_register(REG_ISSUE_DELAY, delay);
    write_register(REG_LOOKAHEAD_DEGREE, degree);
    write_register(REG_CONFIDENCE_LIMIT, limit);
    write_register(REG_VIRTUAL_MODE, virt);
  endtask

  // ------------------------------------------------------------------------------------
  // Result side. The sink draws a stall before every result and honors a one-time long
  // hold-off; the checker compares every accepted result with the oldest expectation.
  // ------------------------------------------------------------------------------------
  always begin : result_sink
    int unsigned stall;
    @(negedge clk);
    if (hold_request > 0) begin
      stall = hold_request;
      hold_request = 0;
    end else begin
      stall = (sink_gap_max > 0) ? $urandom_range(0, sink_gap_max) : 0;
    end
    if (stall > 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!(out_valid && !rst));
  end

  task automatic note_mismatch(input string what, input prefetch_result_t want,
                               input prefetch_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] %s: expected pf_valid=%0b addr=%h fill=%0b, got pf_valid=%0b addr=%h fill=%0b",
               $time, what, want.pf_valid, want.pf_address, want.fill_this_level,
               got.pf_valid, got.pf_address, got.fill_this_level);
  endtask

  always @(posedge clk) begin : result_checker
    prefetch_result_t want;
    prefetch_result_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{pf_valid, pf_address, fill_this_level};
      if (pending_results.size() == 0) begin
        note_mismatch("result with no request pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.pf_valid === 1'b1) prefetch_results++;
        if (got.pf_valid !== want.pf_valid || got.pf_address !== want.pf_address ||
            got.fill_this_level !== want.fill_this_level)
          note_mismatch($sformatf("result %0d differs", results_checked), want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ------------------------------------------------------------------------------------
  // Random traffic: mostly steady strides from a few instructions that share two tracker
  // sets, mixed with ticks that move the cache clock forward, plus noise accesses that
  // force evictions and ticks with arbitrary cycle values.
  // ------------------------------------------------------------------------------------
  function automatic logic [LINE_W-1:0] pick_stride();
    int unsigned         sel;
    logic [LINE_W-1:0]   mag;
    sel = $urandom_range(0, 9);
    if (sel < 6)       mag = $urandom_range(1, 4);
    else if (sel < 8)  mag = $urandom_range(5, 70);
    else if (sel == 8) mag = LINE_W'(rand64());
    else               mag = '0;
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic init_streams();
    logic [7:0] set_a;
    logic [7:0] set_b;
    set_a = $urandom_range(0, 255);
    set_b = $urandom_range(0, 255);
    for (int s = 0; s < STREAMS; s++) begin
      stream_ip[s]        = IP_W'(rand64());
      stream_ip[s][7:0]   = (s < STREAMS / 2) ? set_a : set_b;
      stream_line[s]      = LINE_W'(rand64());
      stream_step[s]      = pick_stride();
    end
    cache_now = CYCLE_W'(rand64());
  endtask

  task automatic run_traffic(input int unsigned count, input int unsigned send_gap,
                             input int unsigned sink_gap);
    item_t       it;
    int unsigned sel;
    int unsigned s;
    send_gap_max = send_gap;
    sink_gap_max = sink_gap;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      s   = $urandom_range(0, STREAMS - 1);
      // Ticks carry random ip and line values, which the block must ignore.
      it = make_item(REQ_TICK, IP_W'(rand64()), LINE_W'(rand64()), cache_now,
                     $urandom_range(0, 1), $urandom_range(0, 3) != 0);
      if (sel < 45) begin
        if ($urandom_range(0, 15) == 0) stream_step[s] = pick_stride();
        stream_line[s] = stream_line[s] + stream_step[s];
        it.is_tick = REQ_ACCESS;
        it.ip      = stream_ip[s];
        it.line    = stream_line[s];
        cache_now  = cache_now + $urandom_range(0, 3);
      end else if (sel < 88) begin
        cache_now    = cache_now + $urandom_range(0, cfg_delay / 4 + 4);
        it.cycle_now = cache_now;
      end else if (sel < 96) begin
        // A stranger in a busy set pushes out whichever stream was used least recently.
        it.is_tick = REQ_ACCESS;
        if ($urandom_range(0, 1)) it.ip[7:0] = stream_ip[s][7:0];
        if ($urandom_range(0, 3) == 0) stream_ip[s][IP_W-1:8] = $urandom();
      end else begin
        it.cycle_now = CYCLE_W'(rand64());
      end
      send_request(it);
    end
  endtask

  // ------------------------------------------------------------------------------------
  // Tests.
  // ------------------------------------------------------------------------------------

  // Hand-built sequences at the reset settings: a tick with nothing armed, a falling
  // stride at the top of the line space with a refused and then accepted prefetches down
  // to the last one, a lookahead that stops at a page boundary, the line field extremes,
  // and an issue time that wraps past the top of the cycle counter.
  task automatic test_directed_training();
    logic [CYCLE_W-1:0] t0;
    send_gap_max = 7;
    sink_gap_max = 7;
    t0 = 48'd1000;
    send_request(make_item(REQ_TICK, '0, '0, '0, 1'b1, 1'b1));
    send_request(make_item(REQ_ACCESS, IP_TOP, LINE_TOP - 42'd1, t0, 1'b0, 1'b0));
    send_request(make_item(REQ_ACCESS, IP_TOP, LINE_TOP - 42'd3, t0, 1'b0, 1'b0));
    send_request(make_item(REQ_ACCESS, IP_TOP, LINE_TOP - 42'd5, t0, 1'b0, 1'b0));
    send_request(make_item(REQ_TICK, '0, '0, t0 + 48'd10, 1'b1, 1'b1));
    send_request(make_item(REQ_TICK, '0, '0, t0 + 48'd30, 1'b0, 1'b0));
    send_request(make_item(REQ_TICK, IP_TOP, LINE_TOP, t0 + 48'd31, 1'b1, 1'b1));
    send_request(make_item(REQ_TICK, '0, '0, t0 + 48'd61, 1'b0, 1'b1));
    send_request(make_item(REQ_TICK, '0, '0, t0 + 48'd91, 1'b1, 1'b1));
    send_request(make_item(REQ_TICK, '0, '0, t0 + 48'd200, 1'b1, 1'b1));
    // Line 0x3E steps to 0x40, which lies in the next page.
    send_request(make_item(REQ_ACCESS, '0, 42'h3A, 48'd2000, 1'b1, 1'b1));
    send_request(make_item(REQ_ACCESS, '0, 42'h3C, 48'd2000, 1'b1, 1'b1));
    send_request(make_item(REQ_ACCESS, '0, 42'h3E, 48'd2000, 1'b1, 1'b1));
    send_request(make_item(REQ_TICK, '0, '0, 48'd2030, 1'b1, 1'b1));
    send_request(make_item(REQ_TICK, '0, '0, 48'd2100, 1'b1, 1'b1));
    send_request(make_item(REQ_ACCESS, 48'd1, '0, 48'd3000, 1'b0, 1'b0));
    send_request(make_item(REQ_ACCESS, 48'd1, LINE_TOP, 48'd3001, 1'b0, 1'b0));
    // Armed just below the top of the counter, so the issue time wraps to a small value.
    send_request(make_item(REQ_ACCESS, 48'd2, 42'h100, CYCLE_TOP - 48'd15, 1'b0, 1'b0));
    send_request(make_item(REQ_ACCESS, 48'd2, 42'h101, CYCLE_TOP - 48'd14, 1'b0, 1'b0));
    send_request(make_item(REQ_ACCESS, 48'd2, 42'h102, CYCLE_TOP - 48'd13, 1'b0, 1'b0));
    send_request(make_item(REQ_TICK, '0, '0, CYCLE_TOP - 48'd10, 1'b1, 1'b1));
    wait_idle();
  endtask

  // Writes to indexes outside the map, a degree of zero and a confidence limit of zero,
  // each with upper data bits set that the register must drop.
  task automatic test_register_corners();
    write_register(8'd4, 8'h55);
    write_register(8'hFF, 8'hAA);
    write_register(REG_LOOKAHEAD_DEGREE, 8'hF0);
    write_register(REG_CONFIDENCE_LIMIT, 8'hFC);
    send_request(make_item(REQ_ACCESS, 48'd3, 42'd10, 48'd5000, 1'b1, 1'b1));
    send_request(make_item(REQ_ACCESS, 48'd3, 42'd13, 48'd5000, 1'b1, 1'b1));
    send_request(make_item(REQ_TICK, '0, '0, 48'd9000, 1'b1, 1'b1));
    wait_idle();
    write_register(REG_LOOKAHEAD_DEGREE, 8'h02);
    send_request(make_item(REQ_ACCESS, 48'd3, 42'd16, 48'd9000, 1'b0, 1'b0));
    send_request(make_item(REQ_TICK, '0, '0, 48'd9100, 1'b1, 1'b1));
    send_request(make_item(REQ_TICK, '0, '0, 48'd9200, 1'b0, 1'b1));
    wait_idle();
  endtask

  // Random traffic under a series of register settings, the extremes among them, with
  // the idle patterns of both sides varied from phase to phase.
  task automatic test_random_phases();
    init_streams();
    write_all_registers(8'd30, 8'd3, 8'd2, 8'd0);
    run_traffic(125, 7, 7);
    wait_idle();
    write_all_registers(8'd0, 8'd15, 8'd3, 8'd1);
    run_traffic(125, 0, 0);
    wait_idle();
    write_all_registers(8'hFF, 8'd1, 8'd1, 8'd0);
    run_traffic(125, 7, 0);
    wait_idle();
    write_all_registers($urandom_range(0, 255), $urandom_range(1, 15),
                        $urandom_range(1, 3), $urandom_range(0, 1));
    run_traffic(125, 0, 7);
    wait_idle();
    write_all_registers(8'd5, 8'hF7, 8'h0C, 8'hFE);
    run_traffic(125, 7, 7);
    wait_idle();
    write_all_registers($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
    run_traffic(125, 7, 7);
    wait_idle();
  endtask

  // The sink stops taking results for a long stretch while requests keep coming with no
  // gaps, so the internal queue fills and the block has to hold off its input.
  task automatic test_backpressure();
    write_all_registers(8'd2, 8'd4, 8'd1, 8'd1);
    hold_request = 200;
    run_traffic(40, 0, 0);
    wait_idle();
  endtask

  initial begin
    mismatch_count   = 0;
    requests_sent    = 0;
    results_checked  = 0;
    prefetch_results = 0;
    register_writes  = 0;
    cycle_count      = 0;
    send_gap_max     = 0;
    sink_gap_max     = 0;
    hold_request     = 0;
    reset_predictor();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_training();
    test_register_corners();
    test_random_phases();
    test_backpressure();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results (%0d carrying a prefetch) for %0d requests, %0d register writes.",
             results_checked, prefetch_results, requests_sent, register_writes);
    $display("Covered directed stride corners, register edge values, random phases and a long stall.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total.", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ipsd_pkg.sv
hdl/ipsd_ram.sv
hdl/ipsd_front.sv
hdl/ipsd_back.sv
hdl/ip_stride_prefetcher_delayed_core.sv
tb/ip_stride_prefetcher_delayed_core_tb.sv
